### sv/alist_pkg.sv
`timescale 1ns / 1ps

package alist_pkg;

	// Fixed widths of the request and result fields
	localparam int FUNC_W   = 2;
	localparam int KEY_IO_W = 32;
	localparam int POS_W    = 10;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;

	// Defaults for the top-level parameters
	localparam int DEPTH_DEF     = 1024;
	localparam int KEY_WIDTH_DEF = 32;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_REMOVE = 2'd2,
		FUNC_SEARCH = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_BAD_POS   = 2'd2,
		STATUS_NOT_FOUND = 2'd3
	} status_t;

	// Storage strobes from the sequencer
	typedef struct packed {
		logic we;
		logic rd_en;
	} mem_ctl_t;

endpackage

### sv/alist_mem.sv
`timescale 1ns / 1ps

// Single-port-write, single-port-read storage, registered read data.
module alist_mem import alist_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  mem_ctl_t             ctl,
	input  logic [AW-1:0]        waddr,
	input  logic [KEY_WIDTH-1:0] wdata,
	input  logic [AW-1:0]        raddr,
	output logic [KEY_WIDTH-1:0] rdata
);

	logic [KEY_WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/alist_ctrl.sv
`timescale 1ns / 1ps

// Request sequencer: count register, shift/scan walker, result register.
module alist_ctrl import alist_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW       = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [FUNC_W-1:0]    func,
	input  logic [KEY_WIDTH-1:0] key,
	input  logic [POS_W-1:0]     position,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	output logic [KEY_WIDTH-1:0] key_out,
	output logic [POS_W-1:0]     found_position,
	output logic [COUNT_W-1:0]   count,
	output mem_ctl_t             mem_ctl,
	output logic [AW-1:0]        mem_waddr,
	output logic [KEY_WIDTH-1:0] mem_wdata,
	output logic [AW-1:0]        mem_raddr,
	input  logic [KEY_WIDTH-1:0] mem_rdata
);

	localparam int XW  = (CW > POS_W) ? CW : POS_W;
	localparam int XCW = (CW > COUNT_W) ? CW : COUNT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [AW-1:0]        idx_q;
	logic                 first_q;
	logic [KEY_WIDTH-1:0] key_q;
	status_t              status_q;
	logic [KEY_WIDTH-1:0] kout_q;
	logic [AW-1:0]        fpos_q;

	logic                 out_valid_q;
	status_t              out_status_q;
	logic [KEY_WIDTH-1:0] out_key_q;
	logic [POS_W-1:0]     out_fpos_q;
	logic [COUNT_W-1:0]   out_count_q;

	func_t         func_in;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] count_x;
	logic          pos_ok;
	logic          full;
	logic          empty;
	logic [CW-1:0] nxt;
	logic          more;
	logic          hit;
	logic [XW-1:0] fpos_x;
	logic [XCW-1:0] count_w;

	assign func_in = func_t'(func);
	assign pos_x   = XW'(position);
	assign count_x = XW'(count_q);
	assign pos_ok  = pos_x < count_x;
	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign nxt     = CW'(idx_q) + CW'(1);
	assign more    = nxt < count_q;
	assign hit     = mem_rdata == key_q;
	assign fpos_x  = XW'(fpos_q);
	assign count_w = XCW'(count_q);

	assign in_ready       = state_q == ST_IDLE;
	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign key_out        = out_key_q;
	assign found_position = out_fpos_q;
	assign count          = out_count_q;

	// Memory strobes
	always_comb begin
		mem_ctl   = '0;
		mem_waddr = '0;
		mem_wdata = key;
		mem_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (func_in)
						FUNC_APPEND: begin
							mem_ctl.we = !full;
							mem_waddr  = count_q[AW-1:0];
						end
						FUNC_REMOVE: begin
							mem_ctl.rd_en = pos_ok;
							mem_raddr     = pos_x[AW-1:0];
						end
						FUNC_SEARCH: begin
							mem_ctl.rd_en = !empty;
						end
						FUNC_CLEAR: begin
						end
					endcase
				end
			end
			ST_REMOVE: begin
				// Move the word just read one place down, read the next
				mem_ctl.we    = !first_q;
				mem_waddr     = idx_q - AW'(1);
				mem_wdata     = mem_rdata;
				mem_ctl.rd_en = more;
				mem_raddr     = nxt[AW-1:0];
			end
			ST_SEARCH: begin
				mem_ctl.rd_en = !hit && more;
				mem_raddr     = nxt[AW-1:0];
			end
			ST_FINISH: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			first_q      <= 1'b0;
			key_q        <= '0;
			status_q     <= STATUS_OK;
			kout_q       <= '0;
			fpos_q       <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= STATUS_OK;
			out_key_q    <= '0;
			out_fpos_q   <= '0;
			out_count_q  <= '0;
		end else begin
			// ST_FINISH always leaves a valid result in the output register
			if (out_ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						status_q <= STATUS_OK;
						kout_q   <= '0;
						fpos_q   <= '0;
						key_q    <= key;
						unique case (func_in)
							FUNC_CLEAR: begin
								count_q <= '0;
								state_q <= ST_FINISH;
							end
							FUNC_APPEND: begin
								if (full) begin
									status_q <= STATUS_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
								state_q <= ST_FINISH;
							end
							FUNC_REMOVE: begin
								if (pos_ok) begin
									idx_q   <= pos_x[AW-1:0];
									first_q <= 1'b1;
									state_q <= ST_REMOVE;
								end else begin
									status_q <= STATUS_BAD_POS;
									state_q  <= ST_FINISH;
								end
							end
							FUNC_SEARCH: begin
								if (empty) begin
									status_q <= STATUS_NOT_FOUND;
									state_q  <= ST_FINISH;
								end else begin
									idx_q   <= '0;
									state_q <= ST_SEARCH;
								end
							end
						endcase
					end
				end
				ST_REMOVE: begin
					first_q <= 1'b0;
					if (first_q) begin
						kout_q <= mem_rdata;
					end
					if (more) begin
						idx_q <= nxt[AW-1:0];
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= ST_FINISH;
					end
				end
				ST_SEARCH: begin
					priority if (hit) begin
						fpos_q  <= idx_q;
						state_q <= ST_FINISH;
					end else if (more) begin
						idx_q <= nxt[AW-1:0];
					end else begin
						status_q <= STATUS_NOT_FOUND;
						state_q  <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_key_q    <= kout_q;
						out_fpos_q   <= fpos_x[POS_W-1:0];
						out_count_q  <= count_w[COUNT_W-1:0];
						state_q      <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

### sv/array_list_engine.sv
`timescale 1ns / 1ps

// Array list engine: an ordered list of signed keys held in one synchronous
// memory of DEPTH words plus an entry count. One request at a time; each
// request gives exactly one result carrying status and the count after the
// operation. Clear and append go straight to the finish state; remove at
// position p makes one read and one write-back per later entry as the tail
// moves down; search reads entries from position 0 up until the key is found
// or the count is reached. A new request is taken as soon as the previous
// result sits in the output register, even while that result waits for
// out_ready. Memory words are never cleared: clear only resets the count,
// and only positions below the count are read.
module array_list_engine import alist_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [FUNC_W-1:0]   func,
	input  logic [KEY_IO_W-1:0] key_in,
	input  logic [POS_W-1:0]    position,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [KEY_IO_W-1:0] key_out,
	output logic [POS_W-1:0]    found_position,
	output logic [COUNT_W-1:0]  count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [KEY_WIDTH-1:0] key_kw;      // request key at storage width
	logic [KEY_WIDTH-1:0] key_out_kw;  // removed key at storage width
	mem_ctl_t             mem_ctl;
	logic [AW-1:0]        mem_waddr;
	logic [KEY_WIDTH-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [KEY_WIDTH-1:0] mem_rdata;

	// Keys are stored and compared at KEY_WIDTH bits: the 32-bit request key
	// is truncated or sign-extended on the way in, and the removed key is
	// sign-extended or truncated back to 32 bits on the way out.
	generate
		if (KEY_WIDTH <= KEY_IO_W) begin : g_key_narrow_in
			assign key_kw = key_in[KEY_WIDTH-1:0];
		end else begin : g_key_wide_in
			assign key_kw = {{(KEY_WIDTH - KEY_IO_W){key_in[KEY_IO_W-1]}}, key_in};
		end
		if (KEY_WIDTH >= KEY_IO_W) begin : g_key_wide_out
			assign key_out = key_out_kw[KEY_IO_W-1:0];
		end else begin : g_key_narrow_out
			assign key_out = {{(KEY_IO_W - KEY_WIDTH){key_out_kw[KEY_WIDTH-1]}}, key_out_kw};
		end
	endgenerate

	// Sequencer: count, tail shift on remove, linear scan on search
	alist_ctrl #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.key            (key_kw),
		.position       (position),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.key_out        (key_out_kw),
		.found_position (found_position),
		.count          (count),
		.mem_ctl        (mem_ctl),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata)
	);

	// Entry storage; writes during a shift always land below the next read,
	// so no forwarding is needed.
	alist_mem #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

### dv/tb_array_list_engine.sv
`timescale 1ns / 1ps

module tb_array_list_engine;
	import alist_pkg::*;

	localparam int LIST_DEPTH  = DEPTH_DEF;
	localparam int RANDOM_REQS = 557;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		func_t               op;
		logic [KEY_IO_W-1:0] key;
		logic [POS_W-1:0]    pos;
	} list_request_t;

	typedef struct {
		status_t             status;
		logic [KEY_IO_W-1:0] key;
		logic [POS_W-1:0]    pos;
		logic [COUNT_W-1:0]  cnt;
	} list_result_t;

	typedef enum {RX_OPEN, RX_HALF, RX_SPARSE} rx_pattern_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [FUNC_W-1:0]   func = FUNC_CLEAR;
	logic [KEY_IO_W-1:0] key_in = '0;
	logic [POS_W-1:0]    position = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [KEY_IO_W-1:0] key_out;
	logic [POS_W-1:0]    found_position;
	logic [COUNT_W-1:0]  count;

	array_list_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.key_in         (key_in),
		.position       (position),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.key_out        (key_out),
		.found_position (found_position),
		.count          (count)
	);

	// Requests waiting for the driver, and a shadow of the list as the
	// generator expects it to be once those requests have run. The shadow
	// only steers stimulus toward valid positions and present keys.
	list_request_t       request_q[$];
	logic [KEY_IO_W-1:0] planned_list[$];
	int                  total_requests = 0;

	// Predicted list contents and the results still owed by the block
	logic [KEY_IO_W-1:0] list_store[LIST_DEPTH];
	int                  list_len = 0;
	list_result_t        list_result_q[$];

	int                  requests_accepted = 0;
	int                  results_seen = 0;
	int                  mismatch_count = 0;

	// Sender burst/gap and receiver pattern state
	list_request_t       staged_req;
	int                  burst_left = 0;
	int                  gap_left = 0;
	rx_pattern_t         rx_pattern = RX_OPEN;
	int                  rx_left = 0;
	int                  hold_left = 0;
	bit                  held_off = 1'b0;
	list_result_t        want;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Predictor: applies one request to the list copy and returns the result
	// it must produce. Clear keeps stale words; only the length drops.
	function automatic list_result_t apply_list_op(func_t op, logic [KEY_IO_W-1:0] k,
			logic [POS_W-1:0] p);
		list_result_t r;
		bit           hit;
		r.status = STATUS_OK;
		r.key    = '0;
		r.pos    = '0;
		hit      = 1'b0;
		case (op)
		FUNC_CLEAR: begin
			list_len = 0;
		end
		FUNC_APPEND: begin
			if (list_len >= LIST_DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				list_store[list_len] = k;
				list_len++;
			end
		end
		FUNC_REMOVE: begin
			// position equal to the length is out of range too
			if (int'(p) >= list_len) begin
				r.status = STATUS_BAD_POS;
			end else begin
				r.key = list_store[p];
				for (int i = int'(p) + 1; i < list_len; i++)
					list_store[i-1] = list_store[i];
				list_len--;
			end
		end
		default: begin
			// search: first matching position wins
			r.status = STATUS_NOT_FOUND;
			for (int i = 0; i < list_len && !hit; i++) begin
				if (list_store[i] == k) begin
					hit      = 1'b1;
					r.status = STATUS_OK;
					r.pos    = POS_W'(i);
				end
			end
		end
		endcase
		r.cnt = COUNT_W'(list_len);
		return r;
	endfunction

	task automatic queue_request(func_t op, logic [KEY_IO_W-1:0] k, logic [POS_W-1:0] p);
		list_request_t r;
		r.op  = op;
		r.key = k;
		r.pos = p;
		request_q.push_back(r);
		total_requests++;
		case (op)
		FUNC_CLEAR:  planned_list.delete();
		FUNC_APPEND: if (planned_list.size() < LIST_DEPTH) planned_list.push_back(k);
		FUNC_REMOVE: if (int'(p) < planned_list.size()) planned_list.delete(int'(p));
		default: ;
		endcase
	endtask

	task automatic note_mismatch(list_result_t w);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("result %0d: got status %0d key %h pos %0d count %0d;",
				results_seen, status, key_out, found_position, count);
			$display("    wanted status %0d key %h pos %0d count %0d",
				w.status, w.key, w.pos, w.cnt);
		end
	endtask

	// Stimulus, then end of run
	initial begin : stimulus
		int                  n;
		int                  sz;
		int                  roll;
		int                  sel;
		func_t               op;
		logic [KEY_IO_W-1:0] k;
		logic [POS_W-1:0]    p;

		// Directed: empty list, key extremes, duplicates, bad positions
		queue_request(FUNC_SEARCH, 32'h0000_0000, 10'd0);
		queue_request(FUNC_REMOVE, 32'hFFFF_FFFF, 10'd0);
		queue_request(FUNC_REMOVE, 32'h0000_0000, 10'd1023);
		queue_request(FUNC_APPEND, 32'h7FFF_FFFF, 10'd1023);
		queue_request(FUNC_APPEND, 32'h8000_0000, 10'd0);
		queue_request(FUNC_APPEND, 32'h0000_0000, 10'd0);
		queue_request(FUNC_APPEND, 32'hFFFF_FFFF, 10'd0);
		queue_request(FUNC_APPEND, 32'h8000_0000, 10'd0);
		queue_request(FUNC_SEARCH, 32'h8000_0000, 10'd1023);
		queue_request(FUNC_SEARCH, 32'hFFFF_FFFF, 10'd0);
		queue_request(FUNC_SEARCH, 32'h0000_3039, 10'd0);
		queue_request(FUNC_REMOVE, 32'h0000_0000, 10'd5);
		queue_request(FUNC_REMOVE, 32'h0000_0000, 10'd1023);
		queue_request(FUNC_REMOVE, 32'h0000_0000, 10'd1);
		queue_request(FUNC_SEARCH, 32'h8000_0000, 10'd0);
		queue_request(FUNC_REMOVE, 32'h0000_0000, 10'd3);
		queue_request(FUNC_REMOVE, 32'h0000_0000, 10'd0);
		queue_request(FUNC_CLEAR, 32'hFFFF_FFFF, 10'd1023);
		queue_request(FUNC_SEARCH, 32'h0000_0000, 10'd0);
		queue_request(FUNC_REMOVE, 32'h0000_0000, 10'd0);
		queue_request(FUNC_APPEND, 32'h1234_5678, 10'd0);
		queue_request(FUNC_CLEAR, 32'h0, 10'd0);
		queue_request(FUNC_CLEAR, 32'h0, 10'd0);

		// Random mix on short lists; long lists get more clears and fewer appends
		for (n = 0; n < RANDOM_REQS; n++) begin
			sz   = planned_list.size();
			roll = $urandom_range(0, 99);
			if (roll < 3 || (sz > 60 && roll < 10))
				op = FUNC_CLEAR;
			else if (roll < (sz > 40 ? 25 : 42))
				op = FUNC_APPEND;
			else if (roll < 72)
				op = FUNC_REMOVE;
			else
				op = FUNC_SEARCH;

			k = $urandom;
			p = POS_W'($urandom);
			case (op)
			FUNC_APPEND: begin
				sel = $urandom_range(0, 3);
				// small values and copies of present keys make duplicates
				if (sel == 2)
					k = int'($urandom_range(0, 7)) - 4;
				else if (sel == 3 && sz > 0)
					k = planned_list[$urandom_range(0, sz - 1)];
			end
			FUNC_REMOVE: begin
				if (sz > 0 && $urandom_range(0, 4) != 0)
					p = POS_W'($urandom_range(0, sz - 1));
				else
					p = POS_W'($urandom_range(sz, LIST_DEPTH - 1));
			end
			FUNC_SEARCH: begin
				if (sz > 0 && $urandom_range(0, 9) < 7)
					k = planned_list[$urandom_range(0, sz - 1)];
			end
			default: ;
			endcase
			queue_request(op, k, p);
		end

		while (requests_accepted < total_requests) @(posedge clk);
		while (results_seen < total_requests) @(posedge clk);
		// room for a stray extra result after a long search or shift
		repeat (1100) @(posedge clk);
		if (mismatch_count == 0 && list_result_q.size() == 0)
			$display("array_list_engine: match");
		else
			$display("array_list_engine: mismatch");
		$finish;
	end

	initial begin
		#25_000_000;
		$display("array_list_engine: mismatch");
		$finish;
	end

	// Driver: bursts of requests with random gaps; the prediction is made
	// when a request is accepted, from the values still on the port.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				list_result_q.push_back(apply_list_op(func_t'(func), key_in, position));
				requests_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || request_q.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					staged_req = request_q.pop_front();
					func       <= staged_req.op;
					key_in     <= staged_req.key;
					position   <= staged_req.pos;
					in_valid   <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	// Receiver: one long hold-off so the block backs up into its request
	// side, otherwise stretches of open, half and sparse ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (!held_off && results_seen >= 60) begin
			held_off = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_pattern = rx_pattern_t'($urandom_range(0, 2));
				rx_left    = $urandom_range(8, 80);
			end
			rx_left--;
			case (rx_pattern)
			RX_OPEN: out_ready <= 1'b1;
			RX_HALF: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Monitor: each result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (list_result_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result %0d arrived with no request pending", results_seen);
			end else begin
				want = list_result_q.pop_front();
				if (status !== want.status || key_out !== want.key ||
						found_position !== want.pos || count !== want.cnt)
					note_mismatch(want);
			end
			results_seen <= results_seen + 1;
		end
	end

endmodule

### sim.f
sv/alist_pkg.sv
sv/alist_mem.sv
sv/alist_ctrl.sv
sv/array_list_engine.sv
dv/tb_array_list_engine.sv
